// ===== design/tcaoq_pkg.sv =====
`timescale 1ns / 1ps

package tcaoq_pkg;

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;

   localparam cmd_type CMD_ENQUEUE    = 2'd0;
   localparam cmd_type CMD_DEQ_OLDEST = 2'd1;
   localparam cmd_type CMD_DEQ_CLASS0 = 2'd2;
   localparam cmd_type CMD_DEQ_CLASS1 = 2'd3;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_EMPTY = 2'd1;
   localparam status_type STATUS_FULL  = 2'd2;

   localparam int VALUE_W = 32;
   localparam int STAMP_W = 32;
   localparam int ENTRY_W = VALUE_W + STAMP_W;

endpackage

// ===== design/two_class_age_ordered_queue.sv =====
// A command taken at an edge with start high and busy low is registered in cmd_ff, class_ff
// and value_ff, and the head entries of both FIFO memories are read into rd0_ff and rd1_ff;
// its result is then registered onto the rsp_ ports, rsp_strobe high for one cycle. busy is
// high while a command is pending, so no new command is taken then. The receiver cannot stall.
// Reset (synchronous, active high) empties both FIFOs and clears the arrival counter;
// the FIFO memories are not cleared.
`timescale 1ns / 1ps

module two_class_age_ordered_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  tcaoq_pkg::cmd_type                  req_cmd,
   input  logic                                req_item_class,
   input  logic signed [tcaoq_pkg::VALUE_W-1:0] req_item_value,
   output logic                                rsp_strobe,
   output tcaoq_pkg::status_type               rsp_status,
   output logic signed [tcaoq_pkg::VALUE_W-1:0] rsp_out_value,
   output logic                                rsp_out_class,
   output logic [tcaoq_pkg::STAMP_W-1:0]       rsp_out_stamp
);
   import tcaoq_pkg::*;

   localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

   logic [ENTRY_W-1:0] mem0 [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] mem1 [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd0_ff, rd1_ff;

   logic [ADDR_W-1:0] head0_ff, head0_in, tail0_ff, tail0_in;
   logic [ADDR_W-1:0] head1_ff, head1_in, tail1_ff, tail1_in;
   logic [CNT_W-1:0]  count0_ff, count0_in, count1_ff, count1_in;
   logic [STAMP_W-1:0] arrival_ff, arrival_in;

   logic               pending_ff, pending_in;
   cmd_type            cmd_ff;
   logic               class_ff;
   logic [VALUE_W-1:0] value_ff;

   logic               strobe_ff, strobe_in;
   status_type         status_ff, status_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic               out_class_ff, out_class_in;
   logic [STAMP_W-1:0] out_stamp_ff, out_stamp_in;

   logic               accept;
   logic               wr0, wr1;
   logic               empty0, empty1, full_sel, cat_older;
   logic [STAMP_W-1:0] stamp_diff;

   assign accept = start && !pending_ff;
   assign busy   = pending_ff;

   assign empty0     = (count0_ff == '0);
   assign empty1     = (count1_ff == '0);
   assign stamp_diff = rd1_ff[STAMP_W-1:0] - rd0_ff[STAMP_W-1:0];
   assign cat_older  = stamp_diff[STAMP_W-1];
   assign full_sel   = class_ff ? (count1_ff == FULL_CNT) : (count0_ff == FULL_CNT);

   always_comb begin
      logic do_pop0;
      logic do_pop1;
      do_pop0      = 1'b0;
      do_pop1      = 1'b0;
      wr0          = 1'b0;
      wr1          = 1'b0;
      head0_in     = head0_ff;
      head1_in     = head1_ff;
      tail0_in     = tail0_ff;
      tail1_in     = tail1_ff;
      count0_in    = count0_ff;
      count1_in    = count1_ff;
      arrival_in   = arrival_ff;
      pending_in   = accept;
      strobe_in    = pending_ff;
      status_in    = STATUS_OK;
      out_value_in = '0;
      out_class_in = 1'b0;
      out_stamp_in = '0;
      if (pending_ff) begin
         case (cmd_ff)
            CMD_ENQUEUE: begin
               if (full_sel) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr0          = !class_ff;
                  wr1          = class_ff;
                  out_class_in = class_ff;
                  out_stamp_in = arrival_ff;
                  arrival_in   = arrival_ff + 1'b1;
               end
            end
            CMD_DEQ_CLASS0: begin
               if (empty0) status_in = STATUS_EMPTY;
               else do_pop0 = 1'b1;
            end
            CMD_DEQ_CLASS1: begin
               if (empty1) status_in = STATUS_EMPTY;
               else do_pop1 = 1'b1;
            end
            CMD_DEQ_OLDEST: begin
               if (empty0 && empty1) status_in = STATUS_EMPTY;
               else if (empty1) do_pop0 = 1'b1;
               else if (empty0) do_pop1 = 1'b1;
               else if (cat_older) do_pop1 = 1'b1;
               else do_pop0 = 1'b1;
            end
            default: status_in = STATUS_OK;
         endcase
         if (wr0) begin
            tail0_in  = (tail0_ff == LAST_ADDR) ? '0 : tail0_ff + 1'b1;
            count0_in = count0_ff + 1'b1;
         end
         if (wr1) begin
            tail1_in  = (tail1_ff == LAST_ADDR) ? '0 : tail1_ff + 1'b1;
            count1_in = count1_ff + 1'b1;
         end
         if (do_pop0) begin
            out_value_in = rd0_ff[ENTRY_W-1:STAMP_W];
            out_stamp_in = rd0_ff[STAMP_W-1:0];
            out_class_in = 1'b0;
            head0_in     = (head0_ff == LAST_ADDR) ? '0 : head0_ff + 1'b1;
            count0_in    = count0_ff - 1'b1;
         end
         if (do_pop1) begin
            out_value_in = rd1_ff[ENTRY_W-1:STAMP_W];
            out_stamp_in = rd1_ff[STAMP_W-1:0];
            out_class_in = 1'b1;
            head1_in     = (head1_ff == LAST_ADDR) ? '0 : head1_ff + 1'b1;
            count1_in    = count1_ff - 1'b1;
         end
      end
   end

   // head entries read at accept; writes land while the command is pending, before the next accept
   always_ff @(posedge clock) begin
      if (wr0) mem0[tail0_ff] <= {value_ff, arrival_ff};
      if (accept) rd0_ff <= mem0[head0_ff];
   end

   always_ff @(posedge clock) begin
      if (wr1) mem1[tail1_ff] <= {value_ff, arrival_ff};
      if (accept) rd1_ff <= mem1[head1_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head0_ff   <= '0;
         tail0_ff   <= '0;
         count0_ff  <= '0;
         head1_ff   <= '0;
         tail1_ff   <= '0;
         count1_ff  <= '0;
         arrival_ff <= '0;
         pending_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         head0_ff   <= head0_in;
         tail0_ff   <= tail0_in;
         count0_ff  <= count0_in;
         head1_ff   <= head1_in;
         tail1_ff   <= tail1_in;
         count1_ff  <= count1_in;
         arrival_ff <= arrival_in;
         pending_ff <= pending_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_cmd;
         class_ff <= req_item_class;
         value_ff <= req_item_value;
      end
      status_ff    <= status_in;
      out_value_ff <= out_value_in;
      out_class_ff <= out_class_in;
      out_stamp_ff <= out_stamp_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_value = out_value_ff;
   assign rsp_out_class = out_class_ff;
   assign rsp_out_stamp = out_stamp_ff;

`ifndef SYNTHESIS
   a_one_response: assert property (@(posedge clock) disable iff (reset)
      pending_ff |=> (strobe_ff && !pending_ff))
      else $error("transaction did not give exactly one response");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count0_ff <= FULL_CNT) && (count1_ff <= FULL_CNT))
      else $error("FIFO count beyond depth");

   a_full_no_stamp: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && (status_ff == STATUS_FULL)) |-> $stable(arrival_ff))
      else $error("arrival counter moved on a dropped enqueue");

   a_empty_no_move: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && (status_ff == STATUS_EMPTY)) |->
         ($stable(count0_ff) && $stable(count1_ff)))
      else $error("FIFO state changed on an empty dequeue");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import tcaoq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int MAX_GAP        = 17;
   localparam int RANDOM_ITEMS   = 450;
   localparam int BLOCK_ITEMS    = 50;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int MAX_PRINTED    = 20;

   typedef struct {
      status_type                status;
      logic signed [VALUE_W-1:0] value;
      logic                      cls;
      logic [STAMP_W-1:0]        stamp;
   } outcome_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   cmd_type                   req_cmd = CMD_ENQUEUE;
   logic                      req_item_class = 1'b0;
   logic signed [VALUE_W-1:0] req_item_value = '0;
   logic                      rsp_strobe;
   status_type                rsp_status;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic                      rsp_out_class;
   logic [STAMP_W-1:0]        rsp_out_stamp;

   // shadow of both class FIFOs and the shared arrival counter
   logic [VALUE_W-1:0] slot_value [2][DEPTH];
   logic [STAMP_W-1:0] slot_stamp [2][DEPTH];
   int unsigned        head [2];
   int unsigned        tail [2];
   int unsigned        fill [2];
   logic [STAMP_W-1:0] next_stamp;

   outcome_type pending_outcomes [$];
   int          mismatches = 0;
   bit          no_gaps = 1'b0;

   two_class_age_ordered_queue #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_item_class (req_item_class),
      .req_item_value (req_item_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_out_value  (rsp_out_value),
      .rsp_out_class  (rsp_out_class),
      .rsp_out_stamp  (rsp_out_stamp)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned bump(int unsigned idx);
      return (idx == DEPTH - 1) ? 0 : idx + 1;
   endfunction

   function automatic outcome_type queue_outcome(cmd_type cmd, logic cls,
                                                 logic [VALUE_W-1:0] val);
      outcome_type        o;
      logic               pick;
      logic [STAMP_W-1:0] diff;
      o.status = STATUS_OK;
      o.value  = '0;
      o.cls    = 1'b0;
      o.stamp  = '0;
      pick     = 1'b0;
      if (cmd == CMD_ENQUEUE) begin
         if (fill[cls] == DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            slot_value[cls][tail[cls]] = val;
            slot_stamp[cls][tail[cls]] = next_stamp;
            tail[cls] = bump(tail[cls]);
            fill[cls]++;
            o.cls      = cls;
            o.stamp    = next_stamp;
            next_stamp = next_stamp + 1;
         end
         return o;
      end
      if (cmd == CMD_DEQ_CLASS0 || cmd == CMD_DEQ_CLASS1) begin
         pick = (cmd == CMD_DEQ_CLASS1);
         if (fill[pick] == 0) begin
            o.status = STATUS_EMPTY;
            return o;
         end
      end else if (fill[0] == 0 && fill[1] == 0) begin
         o.status = STATUS_EMPTY;
         return o;
      end else if (fill[1] == 0) begin
         pick = 1'b0;
      end else if (fill[0] == 0) begin
         pick = 1'b1;
      end else begin
         // cat head wins only when strictly older, by modular difference
         diff = slot_stamp[1][head[1]] - slot_stamp[0][head[0]];
         pick = diff[STAMP_W-1];
      end
      o.value = slot_value[pick][head[pick]];
      o.stamp = slot_stamp[pick][head[pick]];
      o.cls   = pick;
      head[pick] = bump(head[pick]);
      fill[pick]--;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < MAX_PRINTED)
         $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic send_command(cmd_type cmd, logic cls, logic [VALUE_W-1:0] val);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_item_class <= cls;
      req_item_value <= val;
      do @(posedge clock); while (busy);
      pending_outcomes.push_back(queue_outcome(cmd, cls, val));
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_strobe) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected transaction, status", rsp_status, 0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_out_value !== want.value)
               report_mismatch("value", rsp_out_value, want.value);
            if (rsp_out_class !== want.cls)
               report_mismatch("class", rsp_out_class, want.cls);
            if (rsp_out_stamp !== want.stamp)
               report_mismatch("stamp", rsp_out_stamp, want.stamp);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_strobe)
            quiet = 0;
         else
            quiet++;
      end
      $display("** two_class_age_ordered_queue: FAILED **");
      $finish;
   end

   task automatic test_empty_dequeues();
      send_command(CMD_DEQ_OLDEST, 1'b0, 32'h0);
      send_command(CMD_DEQ_CLASS0, 1'b1, 32'hFFFF_FFFF);
      send_command(CMD_DEQ_CLASS1, 1'b0, 32'h0);
   endtask

   task automatic test_oldest_selection();
      send_command(CMD_ENQUEUE, 1'b1, 32'h7FFF_FFFF);
      send_command(CMD_ENQUEUE, 1'b0, 32'h8000_0000);
      send_command(CMD_ENQUEUE, 1'b1, 32'h0);
      send_command(CMD_DEQ_OLDEST, 1'b0, 32'h0);   // cat older
      send_command(CMD_DEQ_OLDEST, 1'b1, 32'h0);   // dog older
      send_command(CMD_DEQ_OLDEST, 1'b0, 32'h0);   // dogs empty
      send_command(CMD_ENQUEUE, 1'b0, 32'hFFFF_FFFF);
      send_command(CMD_DEQ_OLDEST, 1'b0, 32'h0);   // cats empty
      send_command(CMD_ENQUEUE, 1'b1, 32'h5A5A_A5A5);
      send_command(CMD_DEQ_CLASS1, 1'b0, 32'h0);
   endtask

   task automatic test_class0_overflow();
      for (int i = 0; i <= DEPTH; i++)
         send_command(CMD_ENQUEUE, 1'b0, (i % 2) ? 32'h8000_0000 + i : 32'h7FFF_FFFF - i);
   endtask

   task automatic test_random_traffic();
      int enq_pct;
      int cat_pct;
      logic [VALUE_W-1:0] val;
      cmd_type cmd;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % BLOCK_ITEMS == 0) begin
            case ($urandom_range(0, 2))
               0: enq_pct = 15;
               1: enq_pct = 50;
               default: enq_pct = 85;
            endcase
            case ($urandom_range(0, 2))
               0: cat_pct = 10;
               1: cat_pct = 50;
               default: cat_pct = 90;
            endcase
            no_gaps = ($urandom_range(0, 2) == 0);
         end
         case ($urandom_range(0, 15))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'hFFFF_FFFF;
            3: val = 32'h0;
            default: val = $urandom;
         endcase
         if ($urandom_range(0, 99) < enq_pct)
            cmd = CMD_ENQUEUE;
         else
            cmd = cmd_type'($urandom_range(CMD_DEQ_OLDEST, CMD_DEQ_CLASS1));
         send_command(cmd, $urandom_range(0, 99) < cat_pct, val);
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      for (int c = 0; c < 2; c++) begin
         head[c] = 0;
         tail[c] = 0;
         fill[c] = 0;
      end
      next_stamp = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_dequeues();
      test_oldest_selection();
      test_class0_overflow();
      test_random_traffic();

      @(negedge clock);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("** two_class_age_ordered_queue: PASSED **");
      else
         $display("** two_class_age_ordered_queue: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tcaoq_pkg.sv
design/two_class_age_ordered_queue.sv
tb/sv/tb.sv
